@@ rtl/srcq_pkg.sv @@
package srcq_pkg;

    // Store geometry and field widths
    localparam int DEFAULT_STORE_DEPTH = 1024;
    localparam int VALUE_W             = 32;
    localparam int REQ_W               = 2;
    localparam int ANSWER_W            = 11;

    // Stream payload widths (byte multiples)
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    // Request codes (code 3 is unused and dropped)
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOWER  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UPPER  = 2'd2;

    // Result handed from the sequencer to the output register
    typedef struct packed {
        logic                valid;
        logic [ANSWER_W-1:0] answer_count;
        logic                full_error;
    } res_t;

endpackage

@@ rtl/srcq_mem.sv @@
module srcq_mem #(
    parameter int DEPTH = srcq_pkg::DEFAULT_STORE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [srcq_pkg::VALUE_W-1:0] wdata,
    input  logic                         re,
    input  logic [AW-1:0]                raddr,
    output logic [srcq_pkg::VALUE_W-1:0] rdata
);

    logic [srcq_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [srcq_pkg::VALUE_W-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/srcq_ctrl.sv @@
module srcq_ctrl #(
    parameter int STORE_DEPTH = srcq_pkg::DEFAULT_STORE_DEPTH,
    parameter int AW          = $clog2(STORE_DEPTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request side
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [srcq_pkg::REQ_W-1:0]   s_req,
    input  logic [srcq_pkg::VALUE_W-1:0] s_value,
    // result side
    input  logic                         out_free,
    output srcq_pkg::res_t               res,
    // store port
    output logic                         mem_we,
    output logic [AW-1:0]                mem_waddr,
    output logic [srcq_pkg::VALUE_W-1:0] mem_wdata,
    output logic                         mem_re,
    output logic [AW-1:0]                mem_raddr,
    input  logic [srcq_pkg::VALUE_W-1:0] mem_rdata
);

    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int WIDE_W = (CNT_W > srcq_pkg::ANSWER_W) ? CNT_W : srcq_pkg::ANSWER_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_BOUND,
        ST_SHIFT,
        ST_INSERT,
        ST_RESULT
    } state_t;

    state_t                         state_reg, state_next;
    logic [srcq_pkg::REQ_W-1:0]     kind_reg, kind_next;
    logic signed [srcq_pkg::VALUE_W-1:0] x_reg, x_next;
    logic [CNT_W-1:0]               lo_reg, lo_next;
    logic [CNT_W-1:0]               hi_reg, hi_next;
    logic [CNT_W-1:0]               mid_reg, mid_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               j_reg, j_next;
    logic                           wpend_reg, wpend_next;
    logic [AW-1:0]                  waddr_reg, waddr_next;
    logic [CNT_W-1:0]               ans_reg, ans_next;
    logic                           err_reg, err_next;

    logic                           strict;
    logic                           go_right;
    logic [CNT_W-1:0]               lo_n, hi_n, mid_n, half_cnt, jm1;
    logic [WIDE_W-1:0]              ans_wide;

    // Shared compare/halving unit for one bisection step
    assign strict   = (kind_reg != srcq_pkg::REQ_LOWER);
    assign go_right = strict ? ($signed(mem_rdata) <= x_reg) : ($signed(mem_rdata) < x_reg);
    assign lo_n     = go_right ? mid_reg + CNT_W'(1) : lo_reg;
    assign hi_n     = go_right ? hi_reg : mid_reg;
    assign mid_n    = lo_n + ((hi_n - lo_n) >> 1);
    assign half_cnt = count_reg >> 1;
    assign jm1      = j_reg - CNT_W'(1);

    // Next-state and datapath control
    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        x_next     = x_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        count_next = count_reg;
        j_next     = j_reg;
        wpend_next = wpend_reg;
        waddr_next = waddr_reg;
        ans_next   = ans_reg;
        err_next   = err_reg;
        mem_re     = 1'b0;
        mem_raddr  = mid_reg[AW-1:0];
        mem_we     = 1'b0;
        mem_waddr  = waddr_reg;
        mem_wdata  = mem_rdata;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next = s_req;
                    x_next    = s_value;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    mid_next  = half_cnt;
                    err_next  = 1'b0;
                    if (s_req == srcq_pkg::REQ_APPEND &&
                        count_reg >= CNT_W'(STORE_DEPTH)) begin
                        // full store: drop the value, flag it
                        ans_next   = count_reg;
                        err_next   = 1'b1;
                        state_next = ST_RESULT;
                    end else if (s_req inside {srcq_pkg::REQ_APPEND, srcq_pkg::REQ_LOWER,
                                               srcq_pkg::REQ_UPPER}) begin
                        if (count_reg == '0) begin
                            state_next = ST_BOUND;
                        end else begin
                            mem_re     = 1'b1;
                            mem_raddr  = half_cnt[AW-1:0];
                            state_next = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                lo_next  = lo_n;
                hi_next  = hi_n;
                mid_next = mid_n;
                if (lo_n < hi_n) begin
                    mem_re    = 1'b1;
                    mem_raddr = mid_n[AW-1:0];
                end else begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND: begin
                if (kind_reg == srcq_pkg::REQ_APPEND) begin
                    j_next     = count_reg;
                    wpend_next = 1'b0;
                    state_next = ST_SHIFT;
                end else begin
                    ans_next   = count_reg - lo_reg;
                    state_next = ST_RESULT;
                end
            end
            ST_SHIFT: begin
                // move entries up one slot, top down, one per cycle
                if (wpend_reg) begin
                    mem_we = 1'b1;
                end
                if (j_reg > lo_reg) begin
                    mem_re     = 1'b1;
                    mem_raddr  = jm1[AW-1:0];
                    waddr_next = j_reg[AW-1:0];
                    wpend_next = 1'b1;
                    j_next     = jm1;
                end else begin
                    wpend_next = 1'b0;
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg[AW-1:0];
                mem_wdata  = x_reg;
                count_next = count_reg + CNT_W'(1);
                ans_next   = count_reg + CNT_W'(1);
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registers
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        x_reg     <= x_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        j_reg     <= j_next;
        waddr_reg <= waddr_next;
        ans_reg   <= ans_next;
        err_reg   <= err_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            wpend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            wpend_reg <= wpend_next;
        end
    end

    // Result payload, count masked to the field width
    assign ans_wide         = WIDE_W'(ans_reg);
    assign s_ready          = (state_reg == ST_IDLE);
    assign res.valid        = (state_reg == ST_RESULT);
    assign res.answer_count = ans_wide[srcq_pkg::ANSWER_W-1:0];
    assign res.full_error   = err_reg;

endmodule

@@ rtl/sorted_rank_count_query_unit.sv @@
// Sorted rank count query unit.
// Keeps a multiset of signed 32-bit values in ascending order in an on-chip
// store of STORE_DEPTH entries. Each transaction on the s_ channel carries a
// request: append a value, count stored values not less than x, or count
// stored values greater than x. Request code 3 is dropped with no result.
// Every other request returns exactly one transaction on the m_ channel.
// Queries: an accept in the idle state, one bisection step per cycle over the
// store read port, a bound step, then the result. Appends add the shift of
// every entry above the insert point, one entry per cycle through the single
// read and write port, a step to close the shift and an insert step. An append
// to a full store returns at once with full_error set.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register, so the next request may be accepted while it waits; a
// stalled m_ side holds the following result inside the sequencer.
// Reset (aresetn low, synchronous) empties the store and clears m_tvalid;
// store contents need no clearing pass.
module sorted_rank_count_query_unit #(
    parameter int STORE_DEPTH = srcq_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] req_type, [33:2] operand_value, [39:34] zero
    input  logic [srcq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [10:0] answer_count, [11] full_error, [15:12] zero
    output logic [srcq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(STORE_DEPTH);

    srcq_pkg::res_t                 res;
    logic                           out_free;
    logic                           mem_we, mem_re;
    logic [AW-1:0]                  mem_waddr, mem_raddr;
    logic [srcq_pkg::VALUE_W-1:0]   mem_wdata, mem_rdata;
    logic                           m_tvalid_reg;
    logic [srcq_pkg::M_TDATA_W-1:0] m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    srcq_ctrl #(
        .STORE_DEPTH(STORE_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_req    (s_tdata[srcq_pkg::REQ_W-1:0]),
        .s_value  (s_tdata[srcq_pkg::REQ_W +: srcq_pkg::VALUE_W]),
        .out_free (out_free),
        .res      (res),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re   (mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata)
    );

    srcq_mem #(
        .DEPTH(STORE_DEPTH),
        .AW   (AW)
    ) u_mem (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // Output register: loads when empty or being drained
    always_ff @(posedge aclk) begin
        if (res.valid && out_free) begin
            m_tdata_reg <= srcq_pkg::M_TDATA_W'({res.full_error, res.answer_count});
        end
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/srcq_checker.sv @@
module srcq_checker #(
    parameter int STORE_DEPTH = srcq_pkg::DEFAULT_STORE_DEPTH
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [srcq_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [srcq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int ANS_W = srcq_pkg::ANSWER_W;
    localparam logic [ANS_W-1:0] FULL_ANS = ANS_W'(STORE_DEPTH);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid not cleared by reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A valid request makes the unit busy in the following cycle
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[1:0] == srcq_pkg::REQ_APPEND ||
        s_tdata[1:0] == srcq_pkg::REQ_LOWER || s_tdata[1:0] == srcq_pkg::REQ_UPPER)
        |=> !s_tready)
        else $error("request accepted without going busy");

    // A dropped append reports the full count
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[ANS_W] |-> m_tdata[ANS_W-1:0] == FULL_ANS)
        else $error("full_error with wrong count");

endmodule

bind sorted_rank_count_query_unit srcq_checker #(
    .STORE_DEPTH(STORE_DEPTH)
) u_srcq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

@@ test/srcq_result_checker.sv @@
`timescale 1ns / 1ps

// Watches both stream channels, keeps its own sorted copy of the store and
// compares every result transaction against the oldest predicted answer.
module srcq_result_checker
    import srcq_pkg::*;
#(
    parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // [1:0] req_type, [33:2] operand_value, [39:34] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [10:0] answer_count, [11] full_error, [15:12] zero
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   outstanding
);

    typedef struct packed {
        logic [ANSWER_W-1:0] answer_count;
        logic                full_error;
    } answer_t;

    // Ascending copy of the block's store; equal values keep arrival order
    int      held_vals[$];
    answer_t expected_answers[$];
    answer_t want;

    // One line per mismatch, and count it
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Index of the first held value >= x (> x when strict is set)
    function automatic int bound_index(input int x, input bit strict);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = held_vals.size();
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (strict ? (held_vals[mid] <= x) : (held_vals[mid] < x)) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Applies one request to the local store and returns the answer it gives
    function automatic answer_t predict_answer(input logic [REQ_W-1:0] kind, input int x);
        answer_t a;
        a = '0;
        case (kind)
            REQ_APPEND: begin
                // full store drops the value and flags it
                if (held_vals.size() >= STORE_DEPTH) begin
                    a.full_error = 1'b1;
                end else begin
                    held_vals.insert(bound_index(x, 1'b1), x);
                end
                a.answer_count = ANSWER_W'(held_vals.size());
            end
            REQ_LOWER: begin
                a.answer_count = ANSWER_W'(held_vals.size() - bound_index(x, 1'b0));
            end
            default: begin
                a.answer_count = ANSWER_W'(held_vals.size() - bound_index(x, 1'b1));
            end
        endcase
        return a;
    endfunction

    // Request side predicts first, then the result side is compared
    always @(posedge aclk) begin
        if (!aresetn) begin
            held_vals.delete();
            expected_answers.delete();
        end else begin
            // unused request code gives no result
            if (s_tvalid && s_tready &&
                (s_tdata[REQ_W-1:0] inside {REQ_APPEND, REQ_LOWER, REQ_UPPER})) begin
                expected_answers = {expected_answers,
                    predict_answer(s_tdata[REQ_W-1:0], s_tdata[REQ_W +: VALUE_W])};
            end
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("result transaction with no request pending");
                end else begin
                    want = expected_answers.pop_front();
                    if (m_tdata[ANSWER_W-1:0] !== want.answer_count) begin
                        report_mismatch($sformatf("answer_count got %0d expected %0d",
                            m_tdata[ANSWER_W-1:0], want.answer_count));
                    end
                    if (m_tdata[ANSWER_W] !== want.full_error) begin
                        report_mismatch($sformatf("full_error got %b expected %b",
                            m_tdata[ANSWER_W], want.full_error));
                    end
                    if (m_tdata[M_TDATA_W-1:ANSWER_W+1] !== '0) begin
                        report_mismatch($sformatf("pad bits got %h expected 0",
                            m_tdata[M_TDATA_W-1:ANSWER_W+1]));
                    end
                end
            end
        end
        outstanding = expected_answers.size();
    end

endmodule

@@ test/sorted_rank_count_query_unit_tb.sv @@
`timescale 1ns / 1ps

module sorted_rank_count_query_unit_tb;
    import srcq_pkg::*;

    localparam int STORE_DEPTH = DEFAULT_STORE_DEPTH;
    localparam int VAL_MIN     = 32'sh8000_0000;
    localparam int VAL_MAX     = 32'sh7FFF_FFFF;
    localparam int DRAIN_WAIT  = 30;
    localparam int LONG_HOLD   = 400;

    // code 3 is dropped by the block
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int outstanding;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_left = 0;
    int appended      = 0;
    int top_val       = VAL_MIN;
    int sent_vals[$];

    sorted_rank_count_query_unit #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    srcq_result_checker #(
        .STORE_DEPTH(STORE_DEPTH)
    ) result_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random back-pressure plus an occasional long hold-off
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_off_left > 0) begin
                m_tready <= 1'b0;
                hold_off_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // One request transaction; tvalid stays high into the next call unless it idles
    task automatic send_req(input logic [REQ_W-1:0] kind, input int value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-VALUE_W-REQ_W){1'b0}}, value, kind};
        do @(posedge aclk); while (!s_tready);
        if (kind == REQ_APPEND) begin
            sent_vals = {sent_vals, value};
            appended++;
            if (value > top_val) begin
                top_val = value;
            end
        end
    endtask

    // Drop tvalid and wait for every pending answer, then a little longer
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Mostly values near stored ones or a tight range, so duplicates and ties show up
    function automatic int pick_operand();
        int sel;
        sel = $urandom_range(9);
        if (sel < 4 && sent_vals.size() > 0) begin
            return sent_vals[$urandom_range(sent_vals.size() - 1)] + $urandom_range(2) - 1;
        end else if (sel < 7) begin
            return int'($urandom_range(16)) - 8;
        end else if (sel == 7) begin
            return $urandom_range(1) ? VAL_MAX : VAL_MIN;
        end
        return $urandom();
    endfunction

    task automatic send_random(input int append_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < append_pct) begin
            send_req(REQ_APPEND, pick_operand());
        end else if (roll < append_pct + (98 - append_pct) / 2) begin
            send_req(REQ_LOWER, pick_operand());
        end else if (roll < 98) begin
            send_req(REQ_UPPER, pick_operand());
        end else begin
            send_req(REQ_UNUSED, $urandom());
        end
    endtask

    // Non-decreasing fill values land at the top of the store, so no shifting
    function automatic int next_fill_value();
        int step;
        step = $urandom_range(2);
        if (longint'(top_val) + step <= VAL_MAX) begin
            top_val = top_val + step;
        end
        return top_val;
    endfunction

    initial begin : stimulus
        int i;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty store, extremes, duplicates, unused code
        send_req(REQ_LOWER, 0);
        send_req(REQ_UPPER, VAL_MIN);
        send_req(REQ_UNUSED, 32'hFFFF_FFFF);
        send_req(REQ_APPEND, VAL_MIN);
        send_req(REQ_APPEND, VAL_MAX);
        send_req(REQ_APPEND, 0);
        send_req(REQ_APPEND, -1);
        send_req(REQ_APPEND, 0);
        send_req(REQ_APPEND, VAL_MIN);
        send_req(REQ_LOWER, VAL_MIN);
        send_req(REQ_UPPER, VAL_MIN);
        send_req(REQ_LOWER, VAL_MAX);
        send_req(REQ_UPPER, VAL_MAX);
        send_req(REQ_LOWER, 0);
        send_req(REQ_UPPER, 0);
        send_req(REQ_LOWER, -1);
        send_req(REQ_UPPER, -1);
        send_req(REQ_LOWER, 1);
        send_req(REQ_UNUSED, 32'h5A5A_5A5A);
        send_req(REQ_APPEND, 1);
        send_req(REQ_UPPER, -2);
        send_req(REQ_LOWER, 32'sh8000_0001);
        send_req(REQ_UPPER, 32'sh7FFF_FFFE);
        drain_results();

        // Random, sender sparse and receiver sparser
        send_idle_pct = 36;
        recv_idle_pct = 57;
        for (i = 0; i < 450; i++) begin
            if (i == 200) begin
                drain_results();
            end
            send_random(35);
        end
        drain_results();

        // Random, roles swapped; one long receiver hold-off fills the block
        send_idle_pct = 57;
        recv_idle_pct = 36;
        for (i = 0; i < 450; i++) begin
            if (i == 100) begin
                hold_off_left = LONG_HOLD;
            end
            send_random(35);
        end
        drain_results();

        // No idling: fill the store to the top with queries mixed in
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (appended < STORE_DEPTH) begin
            if ($urandom_range(9) == 0) begin
                send_random(0);
            end else begin
                send_req(REQ_APPEND, next_fill_value());
            end
        end

        // Full store: appends are dropped with the error flag
        send_req(REQ_LOWER, VAL_MIN);
        send_req(REQ_UPPER, VAL_MIN);
        send_req(REQ_APPEND, VAL_MIN);
        send_req(REQ_APPEND, VAL_MAX);
        for (i = 0; i < 80; i++) begin
            send_random(40);
        end
        drain_results();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
